@@ rtl/core/wrapped_target_slew_ramp_unit_macros.svh @@
// Assertion macros for the slew ramp unit.
// Used by the top level only; needs nothing else.
`ifndef WRAPPED_TARGET_SLEW_RAMP_UNIT_MACROS_SVH
`define WRAPPED_TARGET_SLEW_RAMP_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define TRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/trs_pkg.sv @@
// Shared types and constants of the slew ramp unit.
// No dependencies.
package trs_pkg;

    localparam int unsigned COUNTS_IN_TURN_DEF = 36000;
    localparam int unsigned CFG_IDX_W          = 2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_OFFSET   = 2'd0,
        CFG_STEP_SIZE     = 2'd1,
        CFG_SETTLE_TICKS  = 2'd2,
        CFG_TIMEOUT_TICKS = 2'd3
    } t_cfg_idx;

    localparam logic [31:0] ZERO_OFFSET_RST   = 32'd0;
    localparam logic [14:0] STEP_SIZE_RST     = 15'd300;
    localparam logic [15:0] SETTLE_TICKS_RST  = 16'd150;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1500;

    typedef struct packed {
        logic [31:0] zero_offset;
        logic [14:0] step_size;
        logic [15:0] settle_ticks;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // item leaving the goal pipeline: goal already wrapped the short way
    typedef struct packed {
        t_op         op;
        logic [31:0] enc;
        logic [31:0] goal;
        logic        at_goal;
    } t_pipe_item;

endpackage

@@ rtl/core/trs_goal_pipe.sv @@
// Goal pipeline: input register and shortest-way goal (constant modulo by reciprocal).
// Depends on trs_pkg.
module trs_goal_pipe #(
    parameter int unsigned COUNTS_IN_TURN = trs_pkg::COUNTS_IN_TURN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_operation,
    input  logic signed [16:0]        i_user_target,
    input  logic signed [31:0]        i_encoder_position,
    input  logic [31:0]               i_zero_offset,
    output logic                      o_valid,
    input  logic                      i_ready,
    output trs_pkg::t_pipe_item       o_item
);

    localparam int unsigned     STAGES  = 6;
    localparam longint unsigned RECIP   = 64'h1_0000_0000 / 64'(COUNTS_IN_TURN);
    localparam longint unsigned KM_L    = 64'h1_0000_0000 % 64'(COUNTS_IN_TURN);
    localparam int unsigned     RECIP_W = $clog2(RECIP + 1);
    localparam int unsigned     P_W     = 32 + RECIP_W;
    localparam int unsigned     R_W     = $clog2(2 * COUNTS_IN_TURN);
    localparam int unsigned     U_W     = $clog2(COUNTS_IN_TURN);
    localparam int unsigned     M_W     = U_W + 1;

    localparam logic [P_W-1:0] RECIP_P  = P_W'(RECIP);
    localparam logic [31:0]    N_Q      = 32'(COUNTS_IN_TURN);
    localparam logic [R_W-1:0] N_R      = R_W'(COUNTS_IN_TURN);
    localparam logic [U_W-1:0] K_MOD    = U_W'(KM_L);
    localparam logic [U_W-1:0] N_LESS_K = U_W'(64'(COUNTS_IN_TURN) - KM_L);
    localparam logic [U_W-1:0] HALF_U   = U_W'(COUNTS_IN_TURN / 2);
    localparam logic [M_W-1:0] N_M      = M_W'(COUNTS_IN_TURN);

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_v;
    logic [STAGES-1:0] adv;
    logic              accept;

    trs_pkg::t_op     r_s0_op;
    logic [16:0]      r_s0_target;
    logic [31:0]      r_s0_enc;
    trs_pkg::t_op     r_s1_op;
    logic [31:0]      r_s1_enc;
    logic [31:0]      r_s1_delta;
    trs_pkg::t_op     r_s2_op;
    logic [31:0]      r_s2_enc;
    logic [31:0]      r_s2_delta;
    logic [RECIP_W-1:0] r_s2_q;
    trs_pkg::t_op     r_s3_op;
    logic [31:0]      r_s3_enc;
    logic             r_s3_neg;
    logic [R_W-1:0]   r_s3_r;
    trs_pkg::t_op     r_s4_op;
    logic [31:0]      r_s4_enc;
    logic [U_W-1:0]   r_s4_m0;
    trs_pkg::t_pipe_item r_s5_item;

    logic [31:0]      c_delta;
    logic [P_W-1:0]   c_qprod;
    logic [31:0]      c_qn;
    logic [31:0]      c_rfull;
    logic [U_W-1:0]   c_um;
    logic [U_W-1:0]   c_m0;
    logic [M_W-1:0]   c_m;
    trs_pkg::t_pipe_item c_item;

    // stage k moves on when the next stage is empty or moving too
    always_comb begin
        adv[STAGES-1] = r_v[STAGES-1] & i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = r_v[k] & (~r_v[k+1] | adv[k+1]);
        end
    end

    assign o_stall = r_v[0] & ~adv[0];
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        n_v[0] = accept | (r_v[0] & ~adv[0]);
        for (int k = 1; k < STAGES; k++) begin
            n_v[k] = adv[k-1] | (r_v[k] & ~adv[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // wrapped distance from encoder to naive goal
    assign c_delta = i_zero_offset + {{15{r_s0_target[16]}}, r_s0_target} - r_s0_enc;

    // quotient estimate, low by at most one
    assign c_qprod = P_W'(r_s1_delta) * RECIP_P;

    assign c_qn    = 32'(r_s2_q) * N_Q;
    assign c_rfull = r_s2_delta - c_qn;

    // final reduction, then fold in the sign of the 32-bit distance
    always_comb begin
        c_um = (r_s3_r >= N_R) ? U_W'(r_s3_r - N_R) : U_W'(r_s3_r);
        if (r_s3_neg) begin
            c_m0 = (c_um >= K_MOD) ? (c_um - K_MOD) : (c_um + N_LESS_K);
        end else begin
            c_m0 = c_um;
        end
    end

    // map into (-half, +half] and add to the encoder count
    always_comb begin
        c_m            = (r_s4_m0 > HALF_U) ? (M_W'(r_s4_m0) - N_M) : M_W'(r_s4_m0);
        c_item.op      = r_s4_op;
        c_item.enc     = r_s4_enc;
        c_item.goal    = r_s4_enc + {{(32 - M_W){c_m[M_W-1]}}, c_m};
        c_item.at_goal = (r_s4_m0 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_op     <= trs_pkg::t_op'(i_operation);
            r_s0_target <= i_user_target;
            r_s0_enc    <= i_encoder_position;
        end
        if (adv[0]) begin
            r_s1_op    <= r_s0_op;
            r_s1_enc   <= r_s0_enc;
            r_s1_delta <= c_delta;
        end
        if (adv[1]) begin
            r_s2_op    <= r_s1_op;
            r_s2_enc   <= r_s1_enc;
            r_s2_delta <= r_s1_delta;
            r_s2_q     <= c_qprod[P_W-1:32];
        end
        if (adv[2]) begin
            r_s3_op  <= r_s2_op;
            r_s3_enc <= r_s2_enc;
            r_s3_neg <= r_s2_delta[31];
            r_s3_r   <= c_rfull[R_W-1:0];
        end
        if (adv[3]) begin
            r_s4_op  <= r_s3_op;
            r_s4_enc <= r_s3_enc;
            r_s4_m0  <= c_m0;
        end
        if (adv[4]) begin
            r_s5_item <= c_item;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_item  = r_s5_item;

endmodule

@@ rtl/core/trs_ramp_core.sv @@
// Ramp state, settle/timeout tracking and the result register.
// Depends on trs_pkg.
module trs_ramp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  trs_pkg::t_pipe_item  i_item,
    input  trs_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_setpoint,
    output logic signed [31:0]   o_final_target,
    output logic                 o_moving,
    output logic                 o_done_res,
    output logic                 o_timed_out
);

    logic [31:0] r_setpoint, n_setpoint;
    logic [31:0] r_goal, n_goal;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] r_reached_tick, n_reached_tick;
    logic        r_reached, n_reached;
    logic        r_active, n_active;
    logic        r_out_valid;
    logic        n_done, n_timed_out;

    logic [31:0] r_out_setpoint;
    logic [31:0] r_out_goal;
    logic        r_out_moving;
    logic        r_out_done;
    logic        r_out_timed_out;

    logic        accept;
    logic [14:0] step;
    logic [31:0] diff;
    logic [31:0] mag;
    logic        reach;
    logic [15:0] elapsed_inc;

    assign o_ready = ~r_out_valid | ~i_stall;
    assign accept  = i_valid & o_ready;

    assign step        = (i_cfg.step_size == '0) ? 15'd1 : i_cfg.step_size;
    assign diff        = r_goal - r_setpoint;
    assign mag         = diff[31] ? (32'd0 - diff) : diff;
    assign reach       = (mag <= {17'd0, step});
    assign elapsed_inc = (r_elapsed != 16'hFFFF) ? (r_elapsed + 16'd1) : r_elapsed;

    always_comb begin
        n_setpoint     = r_setpoint;
        n_goal         = r_goal;
        n_elapsed      = r_elapsed;
        n_reached_tick = r_reached_tick;
        n_reached      = r_reached;
        n_active       = r_active;
        n_done         = 1'b0;
        n_timed_out    = 1'b0;
        if (i_item.op == trs_pkg::OP_START) begin
            n_goal         = i_item.goal;
            n_setpoint     = i_item.enc;
            n_elapsed      = '0;
            n_reached_tick = '0;
            n_reached      = i_item.at_goal;
            n_done         = i_item.at_goal && (i_cfg.settle_ticks == '0);
            n_active       = ~n_done;
        end else if (r_active) begin
            n_elapsed = elapsed_inc;
            if (reach) begin
                n_setpoint = r_goal;
            end else if (diff[31]) begin
                n_setpoint = r_setpoint - 32'(step);
            end else begin
                n_setpoint = r_setpoint + 32'(step);
            end
            if (reach && !r_reached) begin
                n_reached_tick = elapsed_inc;
            end
            n_reached   = r_reached | reach;
            n_done      = reach && ((elapsed_inc - n_reached_tick) >= i_cfg.settle_ticks);
            n_timed_out = !n_done && (elapsed_inc > i_cfg.timeout_ticks);
            n_active    = !(n_done || n_timed_out);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint     <= '0;
            r_goal         <= '0;
            r_elapsed      <= '0;
            r_reached_tick <= '0;
            r_reached      <= 1'b0;
            r_active       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_out_valid <= accept | (r_out_valid & i_stall);
            if (accept) begin
                r_setpoint     <= n_setpoint;
                r_goal         <= n_goal;
                r_elapsed      <= n_elapsed;
                r_reached_tick <= n_reached_tick;
                r_reached      <= n_reached;
                r_active       <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_setpoint  <= n_setpoint;
            r_out_goal      <= n_goal;
            r_out_moving    <= n_active;
            r_out_done      <= n_done;
            r_out_timed_out <= n_timed_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_setpoint     = r_out_setpoint;
    assign o_final_target = r_out_goal;
    assign o_moving       = r_out_moving;
    assign o_done_res     = r_out_done;
    assign o_timed_out    = r_out_timed_out;

endmodule

@@ rtl/core/wrapped_target_slew_ramp_unit.sv @@
// Slew ramp unit, top level: configuration registers, goal pipeline, ramp core.
// Depends on trs_pkg, trs_goal_pipe, trs_ramp_core and the macros header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): one item per accepted beat.
//   Operation start loads a move: the goal is the encoder count nearest the
//   current one that shows the user angle, taken modulo one turn into
//   (-half, +half]; the setpoint jumps to the encoder count. Operation tick
//   is one 10 ms update that slews the setpoint by at most step_size counts.
//   Output channel (o_out_valid / i_out_stall): one result item per input item.
//   Config channel (i_cfg_valid / o_cfg_ready): ready is always high; write
//   only while no item is in flight.
//   Path: six goal pipeline stages (the input register, then the constant
//   modulo steps delta, reciprocal multiply, back-multiply and subtract,
//   reduce and sign fold, wrap and add), then the result register.
//   Throughput: one item per cycle while the receiver does not stall; the
//   ramp state lives in the last stage only, so a tick may follow a start directly.
//   Reset: synchronous, active low; clears the pipeline, the ramp state and
//   loads the default register values.
//   Receiver stall: the result holds; items keep entering until every stage is
//   full, then o_in_stall rises.
`include "wrapped_target_slew_ramp_unit_macros.svh"

module wrapped_target_slew_ramp_unit #(
    parameter int unsigned COUNTS_IN_TURN = trs_pkg::COUNTS_IN_TURN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic signed [16:0]                i_user_target,
    input  logic signed [31:0]                i_encoder_position,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_setpoint,
    output logic signed [31:0]                o_final_target,
    output logic                              o_moving,
    output logic                              o_done_res,
    output logic                              o_timed_out,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [trs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    trs_pkg::t_cfg       r_cfg;
    trs_pkg::t_pipe_item w_item;
    logic                w_pipe_valid;
    logic                w_core_ready;

    assign o_cfg_ready = 1'b1;

    // register file; the index covers exactly the four registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_offset   <= trs_pkg::ZERO_OFFSET_RST;
            r_cfg.step_size     <= trs_pkg::STEP_SIZE_RST;
            r_cfg.settle_ticks  <= trs_pkg::SETTLE_TICKS_RST;
            r_cfg.timeout_ticks <= trs_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (trs_pkg::t_cfg_idx'(i_cfg_index))
                trs_pkg::CFG_ZERO_OFFSET:   r_cfg.zero_offset   <= i_cfg_data;
                trs_pkg::CFG_STEP_SIZE:     r_cfg.step_size     <= i_cfg_data[14:0];
                trs_pkg::CFG_SETTLE_TICKS:  r_cfg.settle_ticks  <= i_cfg_data[15:0];
                trs_pkg::CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // shortest-way goal; state-free, so it runs ahead of the ramp
    trs_goal_pipe #(
        .COUNTS_IN_TURN (COUNTS_IN_TURN)
    ) u_goal_pipe (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_stall            (o_in_stall),
        .i_operation        (i_operation),
        .i_user_target      (i_user_target),
        .i_encoder_position (i_encoder_position),
        .i_zero_offset      (r_cfg.zero_offset),
        .o_valid            (w_pipe_valid),
        .i_ready            (w_core_ready),
        .o_item             (w_item)
    );

    // ramp state and result register
    trs_ramp_core u_ramp_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_pipe_valid),
        .o_ready        (w_core_ready),
        .i_item         (w_item),
        .i_cfg          (r_cfg),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_setpoint     (o_setpoint),
        .o_final_target (o_final_target),
        .o_moving       (o_moving),
        .o_done_res     (o_done_res),
        .o_timed_out    (o_timed_out)
    );

    // input side only backs up when the whole pipe is full behind a held result
    `TRS_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stall without held result")

    // a finished move must sit on its goal and no longer be moving
    `TRS_ASSERT_IMP(a_done_on_goal, i_clk, i_rst_n, o_out_valid && o_done_res, (o_setpoint == o_final_target) && !o_moving && !o_timed_out, "done off goal")

    // result taken with nothing behind it: output goes empty
    `TRS_ASSERT_NXT(a_drain, i_clk, i_rst_n, o_out_valid && !i_out_stall && !w_pipe_valid, !o_out_valid, "result invented")

endmodule

@@ verif/tb_wrapped_target_slew_ramp_unit.sv @@
`timescale 1ns / 100ps
// Testbench for the slew ramp unit: directed and random moves and ticks, each result item
// checked field by field against an in-bench model of the ramp. Needs trs_pkg and the RTL.
module tb_wrapped_target_slew_ramp_unit;

    localparam int TURN       = int'(trs_pkg::COUNTS_IN_TURN_DEF);
    localparam int HALF       = TURN / 2;
    localparam int WDOG_LIMIT = 3000;   // cycles with no handshake at all
    localparam int HOLD_LEN   = 300;    // long receiver hold-off, fills the pipeline
    localparam int DRAIN_WAIT = 12;     // extra wait once both queues are empty

    typedef struct packed {
        trs_pkg::t_op op;
        logic [16:0]  tgt;
        logic [31:0]  enc;
    } t_move_item;

    typedef struct packed {
        logic [31:0] setpoint;
        logic [31:0] final_target;
        logic        moving;
        logic        done_res;
        logic        timed_out;
    } t_ramp_res;

    typedef enum logic [1:0] {FIN_NONE, FIN_DONE, FIN_EXPIRED} t_fin;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    // ---------------------------------------------------------------------------
    // Block ports; everything the bench drives starts at a known value
    // ---------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation = trs_pkg::OP_TICK;
    logic signed [16:0]    i_user_target = '0;
    logic signed [31:0]    i_encoder_position = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [31:0]    o_setpoint;
    logic signed [31:0]    o_final_target;
    logic                  o_moving;
    logic                  o_done_res;
    logic                  o_timed_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [trs_pkg::CFG_IDX_W-1:0] i_cfg_index = trs_pkg::CFG_ZERO_OFFSET;
    logic [31:0]           i_cfg_data = '0;

    wrapped_target_slew_ramp_unit #(
        .COUNTS_IN_TURN(TURN)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_user_target      (i_user_target),
        .i_encoder_position (i_encoder_position),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_setpoint         (o_setpoint),
        .o_final_target     (o_final_target),
        .o_moving           (o_moving),
        .o_done_res         (o_done_res),
        .o_timed_out        (o_timed_out),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------
    // Bench state
    // ---------------------------------------------------------------------------
    t_move_item move_q[$];      // items still to be offered, front is on the pins
    t_ramp_res  ramp_exp_q[$];  // predicted result items, oldest first
    int         err_count = 0;
    bit         item_taken = 1'b0;  // set at the edge that accepts, seen by the sender
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_kick = 1'b0;   // toggled to request one long receiver hold-off
    bit         hold_seen = 1'b0;
    int         hold_left = 0;
    int         wd_count = 0;

    // Shadow registers, updated when a write is accepted
    logic [31:0] cfg_zero;
    logic [14:0] cfg_step;
    logic [15:0] cfg_settle;
    logic [15:0] cfg_timeout;

    // Ramp state as the block should hold it
    logic [31:0] sp_now;
    logic [31:0] goal_now;
    logic [15:0] ticks_run;
    logic [15:0] reach_at;
    logic        reached;
    logic        active;

    // ---------------------------------------------------------------------------
    // Ramp model
    // ---------------------------------------------------------------------------

    // Encoder count nearest enc that shows the user angle; the move is folded
    // into (-half, +half] of a turn. Sums wrap at 32 bits.
    function automatic logic [31:0] wrap_goal(logic [16:0] tgt, logic [31:0] enc);
        logic [31:0] naive;
        longint      span;
        longint      fold;
        naive = cfg_zero + {{15{tgt[16]}}, tgt};
        span  = longint'($signed(naive - enc));
        fold  = span % TURN;
        if (fold < 0)
            fold += TURN;
        if (fold > HALF)
            fold -= TURN;
        return enc + 32'(fold);
    endfunction

    // Reach / settle / timeout check. Settle is tested first so that it wins a tie.
    function automatic t_fin settle_check();
        if (sp_now == goal_now) begin
            if (!reached) begin
                reached  = 1'b1;
                reach_at = ticks_run;
            end
            if (16'(ticks_run - reach_at) >= cfg_settle)
                return FIN_DONE;
        end
        if (ticks_run > cfg_timeout)
            return FIN_EXPIRED;
        return FIN_NONE;
    endfunction

    function automatic t_ramp_res ramp_advance(t_move_item it);
        t_fin      fin;
        logic      was_active;
        longint    stp;
        longint    diff;
        longint    mag;
        t_ramp_res res;
        fin        = FIN_NONE;
        was_active = active;
        if (it.op == trs_pkg::OP_START) begin
            goal_now   = wrap_goal(it.tgt, it.enc);
            sp_now     = it.enc;
            ticks_run  = '0;
            reach_at   = '0;
            reached    = 1'b0;
            active     = 1'b1;
            was_active = 1'b1;
            fin        = settle_check();
        end else if (active) begin
            // a zero step register behaves as one count per tick
            stp  = (cfg_step == 0) ? 1 : longint'(cfg_step);
            diff = longint'($signed(goal_now - sp_now));
            mag  = (diff < 0) ? -diff : diff;
            if (ticks_run != 16'hFFFF)
                ticks_run++;
            if (mag <= stp)
                sp_now = goal_now;
            else if (diff > 0)
                sp_now += 32'(stp);
            else
                sp_now -= 32'(stp);
            fin = settle_check();
        end
        // ticks while idle fall through: state held, flags low
        if (fin != FIN_NONE)
            active = 1'b0;
        res.setpoint     = sp_now;
        res.final_target = goal_now;
        res.moving       = active;
        res.done_res     = was_active && (fin == FIN_DONE);
        res.timed_out    = was_active && (fin == FIN_EXPIRED);
        return res;
    endfunction

    function automatic void cmp_field(string name, logic signed [32:0] want_v,
                                      logic signed [32:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            err_count++;
        end
    endfunction

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // ---------------------------------------------------------------------------
    // Monitor: samples at the rising edge. Checks result items, tracks register
    // writes and predicts each accepted input item.
    // ---------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_ramp_res  want;
        t_move_item seen;
        if (!i_rst_n) begin
            cfg_zero    = trs_pkg::ZERO_OFFSET_RST;
            cfg_step    = trs_pkg::STEP_SIZE_RST;
            cfg_settle  = trs_pkg::SETTLE_TICKS_RST;
            cfg_timeout = trs_pkg::TIMEOUT_TICKS_RST;
            sp_now      = '0;
            goal_now    = '0;
            ticks_run   = '0;
            reach_at    = '0;
            reached     = 1'b0;
            active      = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (ramp_exp_q.size() == 0) begin
                    $error("result item with no expected item waiting");
                    err_count++;
                end else begin
                    want = ramp_exp_q.pop_front();
                    cmp_field("setpoint", 33'($signed(want.setpoint)), 33'(o_setpoint));
                    cmp_field("final_target", 33'($signed(want.final_target)),
                              33'(o_final_target));
                    cmp_field("moving", 33'(want.moving), 33'(o_moving));
                    cmp_field("done_res", 33'(want.done_res), 33'(o_done_res));
                    cmp_field("timed_out", 33'(want.timed_out), 33'(o_timed_out));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (trs_pkg::t_cfg_idx'(i_cfg_index))
                    trs_pkg::CFG_ZERO_OFFSET:   cfg_zero    = i_cfg_data;
                    trs_pkg::CFG_STEP_SIZE:     cfg_step    = i_cfg_data[14:0];
                    trs_pkg::CFG_SETTLE_TICKS:  cfg_settle  = i_cfg_data[15:0];
                    trs_pkg::CFG_TIMEOUT_TICKS: cfg_timeout = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                seen = '{trs_pkg::t_op'(i_operation), i_user_target, i_encoder_position};
                ramp_exp_q.push_back(ramp_advance(seen));
                void'(move_q.pop_front());
                item_taken = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Watchdog: ends the run if no handshake of any kind happens for too long
    // ---------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (wd_count >= WDOG_LIMIT) begin
            $display("FAIL wrapped_target_slew_ramp_unit");
            $finish;
        end else if (!i_rst_n || (i_in_valid && !o_in_stall) ||
                     (o_out_valid && !i_out_stall) || (i_cfg_valid && o_cfg_ready)) begin
            wd_count <= 0;
        end else begin
            wd_count <= wd_count + 1;
        end
    end

    // ---------------------------------------------------------------------------
    // Sender: drives at the falling edge. A stalled item stays on the pins
    // unchanged; valid never looks at the stall.
    // ---------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_in_valid || item_taken) begin
            if (i_rst_n && move_q.size() != 0 && !chance(send_idle_pct)) begin
                i_in_valid         <= 1'b1;
                i_operation        <= move_q[0].op;
                i_user_target      <= move_q[0].tgt;
                i_encoder_position <= move_q[0].enc;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= chance(recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------
    task automatic set_idling(t_idle mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default:   begin send_idle_pct = 21; recv_stall_pct = 21; end
        endcase
    endtask

    // Register write; only called with nothing in flight
    task automatic write_reg(trs_pkg::t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_ramp(logic [31:0] zero, logic [14:0] step, logic [15:0] settle,
                            logic [15:0] tmo);
        write_reg(trs_pkg::CFG_ZERO_OFFSET, zero);
        write_reg(trs_pkg::CFG_STEP_SIZE, 32'(step));
        write_reg(trs_pkg::CFG_SETTLE_TICKS, 32'(settle));
        write_reg(trs_pkg::CFG_TIMEOUT_TICKS, 32'(tmo));
    endtask

    // Sender pauses here until every expected item has come back
    task automatic drain();
        while (move_q.size() != 0 || ramp_exp_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic int rand_target();
        case ($urandom_range(0, 7))
            0:       return -36000;
            1:       return 36000;
            2:       return ($urandom_range(0, 1) != 0) ? HALF : -HALF;
            default: return int'($urandom_range(0, 72000)) - 36000;
        endcase
    endfunction

    function automatic logic [31:0] rand_enc();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF - $urandom_range(0, 40000);
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_move(trs_pkg::t_op op, int tgt, logic [31:0] enc);
        move_q.push_back('{op, 17'(tgt), enc});
    endfunction

    // ticks carry random, ignored payload
    function automatic void push_ticks(int n);
        repeat (n) push_move(trs_pkg::OP_TICK, rand_target(), rand_enc());
    endfunction

    // Mostly whole moves (start, then about enough ticks to finish), some cut
    // short by the next start, and a sprinkling of random noise.
    task automatic fill_moves(int n, int step, int settle);
        int cnt;
        int need;
        int k;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 7) == 0) begin
                k = $urandom_range(1, 6);
                repeat (k) push_move(trs_pkg::t_op'($urandom_range(0, 1)), rand_target(),
                                     rand_enc());
                cnt += k;
            end else begin
                need = (HALF + step - 1) / step + settle + 2;
                k    = $urandom_range(0, need + 2);
                push_move(trs_pkg::OP_START, rand_target(), rand_enc());
                push_ticks(k);
                cnt += k + 1;
            end
        end
    endtask

    // ---------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------
    initial begin : stim
        logic [31:0] zero;
        int          step;
        int          settle;
        int          tmo;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: idle tick, then a short move that keeps settling
        set_idling(IDLE_NONE);
        push_ticks(1);
        push_move(trs_pkg::OP_START, 100, 32'd0);
        push_ticks(2);
        drain();

        // half-turn step, no settle, timeout zero: done wins over timeout on tick one
        set_ramp(32'd0, 15'd18000, 16'd0, 16'd0);
        push_move(trs_pkg::OP_START, 0, 32'd0);              // zero-length move: done on start
        push_ticks(1);                                       // tick while idle
        push_move(trs_pkg::OP_START, 36000, 32'd0);          // full turn folds to no move
        push_move(trs_pkg::OP_START, HALF, 32'd0);           // exactly half a turn: positive
        push_ticks(1);
        push_move(trs_pkg::OP_START, -HALF, 32'd0);          // minus half folds to plus half
        push_ticks(1);
        push_move(trs_pkg::OP_START, -36000, 32'h7FFF_FFFF); // goal across the 32-bit wrap
        push_ticks(1);
        push_move(trs_pkg::OP_START, 36000, 32'h8000_0000);
        push_ticks(2);
        drain();

        // step zero acts as one; first move times out, second ends on done and
        // timeout together
        set_ramp(32'h8000_0000, 15'd0, 16'd2, 16'd3);
        push_move(trs_pkg::OP_START, 5, 32'h8000_0000);
        push_ticks(5);
        push_move(trs_pkg::OP_START, 2, 32'h8000_0000);
        push_ticks(4);
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                zero = 32'h7FFF_FFFF; step = 18000; settle = 0; tmo = 0;
            end else if (p == 1) begin
                zero = 32'h8000_0000; step = $urandom_range(1200, 18000);
                settle = $urandom_range(0, 6); tmo = 65535;
            end else begin
                zero = $urandom; step = $urandom_range(1200, 18000);
                settle = $urandom_range(0, 6); tmo = $urandom_range(0, 30);
            end
            set_ramp(zero, 15'(step), 16'(settle), 16'(tmo));
            set_idling(t_idle'(p % 4));
            fill_moves(80, step, settle);
            // receiver holds off while the sender keeps offering
            if (p == 4)
                hold_kick = ~hold_kick;
            drain();
        end

        if (err_count == 0 && ramp_exp_q.size() == 0) begin
            $display("PASS wrapped_target_slew_ramp_unit");
        end else begin
            $display("FAIL wrapped_target_slew_ramp_unit");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/trs_pkg.sv
rtl/core/trs_goal_pipe.sv
rtl/core/trs_ramp_core.sv
rtl/core/wrapped_target_slew_ramp_unit.sv
verif/tb_wrapped_target_slew_ramp_unit.sv
